// File: hdl/vmlp_pkg.sv
// Shared types, constants and helpers for the vectorscope plot block.
`timescale 1ns / 1ps

package vmlp_pkg;

    localparam int SCOPE_WIDTH_DEF  = 128;
    localparam int SCOPE_HEIGHT_DEF = 128;
    localparam int POS_W_DEF        = 9;

    localparam logic [7:0] LIGHTEN_RESET = 8'd200;

    // Chroma coefficients scaled by 1000.
    localparam logic signed [19:0] U_R_COEF = 20'sd299;
    localparam logic signed [19:0] U_G_COEF = 20'sd587;
    localparam logic signed [19:0] U_B_COEF = 20'sd886;
    localparam logic signed [19:0] V_R_COEF = 20'sd701;
    localparam logic signed [19:0] V_G_COEF = 20'sd587;
    localparam logic signed [19:0] V_B_COEF = 20'sd114;

    localparam int MAG_W       = 18;
    localparam int RECIP_SHIFT = 32;
    localparam int QX_W        = 6;
    localparam int QY_W        = 7;

    localparam logic [10:0] X_GAIN   = 11'd1972;
    localparam logic [11:0] Y_GAIN   = 12'd3508;
    localparam logic [23:0] FIX_DEN  = 24'd10000000;
    // floor(gain * 2^32 / 10^7)
    localparam logic [19:0] X_RECIP  = 20'd846967;
    localparam logic [20:0] Y_RECIP  = 21'd1506674;

    typedef enum logic [1:0] {
        OP_PLOT       = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP_S,
        ST_MAP_P,
        ST_MAP_Q,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] cell_col;
        logic [6:0] cell_row;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [6:0] plot_col;
        logic [6:0] plot_row;
        logic       plot_written;
    } out_item_t;

    function automatic logic [7:0] lightness(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [8:0] sum;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        sum = {1'b0, hi} + {1'b0, lo};
        return sum[8:1];
    endfunction

endpackage

// File: hdl/vmlp_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
`timescale 1ns / 1ps

interface vmlp_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// File: hdl/vmlp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module vmlp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/vmlp_map.sv
// Three-stage mapping of an RGB sample to a scope column and row.
`timescale 1ns / 1ps

module vmlp_map #(
    parameter int SCOPE_WIDTH  = vmlp_pkg::SCOPE_WIDTH_DEF,
    parameter int SCOPE_HEIGHT = vmlp_pkg::SCOPE_HEIGHT_DEF,
    parameter int POS_W        = vmlp_pkg::POS_W_DEF
) (
    input  logic                    clk,
    input  logic [7:0]              red,
    input  logic [7:0]              green,
    input  logic [7:0]              blue,
    output logic signed [POS_W-1:0] col,
    output logic signed [POS_W-1:0] row,
    output logic                    in_range
);

    localparam int MAG_W = vmlp_pkg::MAG_W;
    localparam int SH    = vmlp_pkg::RECIP_SHIFT;
    localparam int QX_W  = vmlp_pkg::QX_W;
    localparam int QY_W  = vmlp_pkg::QY_W;
    localparam int PX_W  = SH + QX_W;
    localparam int PY_W  = SH + QY_W;
    localparam int SX_W  = 29;
    localparam int SY_W  = 30;
    localparam int NX_W  = 31;
    localparam int NY_W  = 32;

    logic signed [19:0] r_s;
    logic signed [19:0] g_s;
    logic signed [19:0] b_s;
    logic signed [19:0] s_calc;
    logic signed [19:0] t_calc;

    logic [MAG_W-1:0] s_mag_reg;
    logic [MAG_W-1:0] t_mag_reg;
    logic             s_neg_reg;
    logic             t_neg_reg;

    logic [PX_W-1:0]  px_reg;
    logic [PY_W-1:0]  py_reg;
    logic [SX_W-1:0]  sx_reg;
    logic [SY_W-1:0]  sy_reg;
    logic             s_neg2_reg;
    logic             t_neg2_reg;

    logic [QX_W-1:0]  qx0;
    logic [QY_W-1:0]  qy0;
    logic [NX_W-1:0]  nx;
    logic [NY_W-1:0]  ny;
    logic [QX_W-1:0]  qx;
    logic [QY_W-1:0]  qy;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic signed [POS_W-1:0] col_next;
    logic signed [POS_W-1:0] row_next;
    logic                    in_range_next;

    logic signed [POS_W-1:0] col_reg;
    logic signed [POS_W-1:0] row_reg;
    logic                    in_range_reg;

    always_comb
    begin
        r_s    = $signed({12'b0, red});
        g_s    = $signed({12'b0, green});
        b_s    = $signed({12'b0, blue});
        s_calc = vmlp_pkg::U_B_COEF * b_s - vmlp_pkg::U_R_COEF * r_s
                 - vmlp_pkg::U_G_COEF * g_s;
        t_calc = vmlp_pkg::V_R_COEF * r_s - vmlp_pkg::V_G_COEF * g_s
                 - vmlp_pkg::V_B_COEF * b_s;
    end

    always_ff @(posedge clk)
    begin
        s_neg_reg <= s_calc[19];
        t_neg_reg <= t_calc[19];
        s_mag_reg <= s_calc[19] ? MAG_W'(-s_calc) : MAG_W'(s_calc);
        t_mag_reg <= t_calc[19] ? MAG_W'(-t_calc) : MAG_W'(t_calc);
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= PX_W'(s_mag_reg) * PX_W'(vmlp_pkg::X_RECIP);
        py_reg     <= PY_W'(t_mag_reg) * PY_W'(vmlp_pkg::Y_RECIP);
        sx_reg     <= SX_W'(s_mag_reg) * SX_W'(vmlp_pkg::X_GAIN);
        sy_reg     <= SY_W'(t_mag_reg) * SY_W'(vmlp_pkg::Y_GAIN);
        s_neg2_reg <= s_neg_reg;
        t_neg2_reg <= t_neg_reg;
    end

    // Reciprocal estimate is at most one low; bump it when the next multiple still fits.
    always_comb
    begin
        qx0 = px_reg[SH +: QX_W];
        qy0 = py_reg[SH +: QY_W];
        nx  = (NX_W'(qx0) + NX_W'(1)) * NX_W'(vmlp_pkg::FIX_DEN);
        ny  = (NY_W'(qy0) + NY_W'(1)) * NY_W'(vmlp_pkg::FIX_DEN);
        qx  = qx0 + QX_W'(NX_W'(sx_reg) >= nx);
        qy  = qy0 + QY_W'(NY_W'(sy_reg) >= ny);
        dx  = s_neg2_reg ? -$signed(POS_W'(qx)) : $signed(POS_W'(qx));
        dy  = t_neg2_reg ? -$signed(POS_W'(qy)) : $signed(POS_W'(qy));
        col_next = $signed(POS_W'(SCOPE_WIDTH / 2)) + dx;
        row_next = $signed(POS_W'(SCOPE_HEIGHT / 2)) - dy;
        in_range_next = !col_next[POS_W-1] && !row_next[POS_W-1]
                        && (col_next < $signed(POS_W'(SCOPE_WIDTH)))
                        && (row_next < $signed(POS_W'(SCOPE_HEIGHT)));
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        in_range_reg <= in_range_next;
    end

    assign col      = col_reg;
    assign row      = row_reg;
    assign in_range = in_range_reg;

endmodule

// File: hdl/vectorscope_max_lightness_plot.sv
// Vectorscope plot that keeps the lightest colour per scope cell.
//
//  channel    dir  handshake        payload
//  samples    in   valid / ready    op, red, green, blue, cell_col, cell_row
//  results    out  valid / ready    out_red/green/blue, plot_col, plot_row, plot_written
//  cfg        in   cfg_wr_en        cfg_wr_data -> lighten_offset
//
// A plot item steps through accept, three mapping stages, store read and update;
// a read or read-and-clear item steps through accept, store read and update.
// The cell store is one RAM with a registered read; each item finishes its
// write before the next item reads, so accesses never overlap.
// After reset a clearing pass writes black to all SCOPE_WIDTH*SCOPE_HEIGHT cells,
// one per cycle (16384 cells by default), before the first item is accepted.
// The result register lets the next item be accepted while a result waits;
// the update step holds until that register is free.
`timescale 1ns / 1ps

module vectorscope_max_lightness_plot #(
    parameter int SCOPE_WIDTH  = vmlp_pkg::SCOPE_WIDTH_DEF,
    parameter int SCOPE_HEIGHT = vmlp_pkg::SCOPE_HEIGHT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    vmlp_stream_if.sink   samples,
    vmlp_stream_if.source results,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    localparam int CELLS  = SCOPE_WIDTH * SCOPE_HEIGHT;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCOPE_WIDTH);
    localparam int ROW_W  = $clog2(SCOPE_HEIGHT);
    localparam int POS_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
    localparam int CCMP_W = COL_W + 1;
    localparam int RCMP_W = ROW_W + 1;
    localparam int RGB_W  = $bits(vmlp_pkg::rgb_t);

    vmlp_pkg::state_t    state_reg;
    vmlp_pkg::state_t    state_next;
    vmlp_pkg::in_item_t  item_reg;
    logic [7:0]          offset_reg;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [IDX_W-1:0]    clr_cnt_next;
    logic                out_valid_reg;
    vmlp_pkg::out_item_t out_data_reg;
    vmlp_pkg::out_item_t out_next;

    logic                    accept;
    logic                    out_free;
    logic                    out_load;
    logic                    clr_done;
    logic signed [POS_W-1:0] map_col;
    logic signed [POS_W-1:0] map_row;
    logic                    map_in_range;
    logic                    rd_in_range;
    logic                    hit;
    logic [COL_W-1:0]        addr_col;
    logic [ROW_W-1:0]        addr_row;
    logic [IDX_W-1:0]        cell_addr;

    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_wr_addr;
    vmlp_pkg::rgb_t          ram_wr_data;
    logic                    ram_rd_en;
    logic [RGB_W-1:0]        ram_rd_data;
    vmlp_pkg::rgb_t          stored;

    logic [8:0]              lsum_r;
    logic [8:0]              lsum_g;
    logic [8:0]              lsum_b;
    vmlp_pkg::rgb_t          lit;
    logic [7:0]              new_light;
    logic [7:0]              old_light;
    logic                    replace;

    vmlp_map #(
        .SCOPE_WIDTH  (SCOPE_WIDTH),
        .SCOPE_HEIGHT (SCOPE_HEIGHT),
        .POS_W        (POS_W)
    ) u_map (
        .clk      (clk),
        .red      (item_reg.red),
        .green    (item_reg.green),
        .blue     (item_reg.blue),
        .col      (map_col),
        .row      (map_row),
        .in_range (map_in_range)
    );

    vmlp_ram #(
        .WIDTH (RGB_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cell_addr),
        .rd_data (ram_rd_data)
    );

    assign stored   = ram_rd_data;
    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign clr_done = (clr_cnt_reg == IDX_W'(CELLS - 1));

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Cell address for the current item
    always_comb
    begin
        rd_in_range = (CCMP_W'(item_reg.cell_col) < CCMP_W'(SCOPE_WIDTH))
                      && (RCMP_W'(item_reg.cell_row) < RCMP_W'(SCOPE_HEIGHT));
        if (item_reg.op == vmlp_pkg::OP_PLOT)
        begin
            addr_col = map_col[COL_W-1:0];
            addr_row = map_row[ROW_W-1:0];
        end
        else
        begin
            addr_col = COL_W'(item_reg.cell_col);
            addr_row = ROW_W'(item_reg.cell_row);
        end
        cell_addr = IDX_W'(addr_row) * IDX_W'(SCOPE_WIDTH) + IDX_W'(addr_col);
        unique case (item_reg.op)
            vmlp_pkg::OP_PLOT:       hit = map_in_range;
            vmlp_pkg::OP_READ:       hit = rd_in_range;
            vmlp_pkg::OP_READ_CLEAR: hit = rd_in_range;
            default:                 hit = 1'b0;
        endcase
    end

    // Lightened colour and comparison
    always_comb
    begin
        lsum_r    = {1'b0, item_reg.red} + {1'b0, offset_reg};
        lsum_g    = {1'b0, item_reg.green} + {1'b0, offset_reg};
        lsum_b    = {1'b0, item_reg.blue} + {1'b0, offset_reg};
        lit.red   = lsum_r[8:1];
        lit.green = lsum_g[8:1];
        lit.blue  = lsum_b[8:1];
        new_light = vmlp_pkg::lightness(lit.red, lit.green, lit.blue);
        old_light = vmlp_pkg::lightness(stored.red, stored.green, stored.blue);
        replace   = (item_reg.op == vmlp_pkg::OP_PLOT) && map_in_range
                    && (old_light < new_light);
    end

    // Result item
    always_comb
    begin
        out_next = '0;
        unique case (item_reg.op)
            vmlp_pkg::OP_PLOT:
            begin
                out_next.out_red      = lit.red;
                out_next.out_green    = lit.green;
                out_next.out_blue     = lit.blue;
                out_next.plot_col     = map_col[6:0];
                out_next.plot_row     = map_row[6:0];
                out_next.plot_written = replace;
            end
            vmlp_pkg::OP_READ, vmlp_pkg::OP_READ_CLEAR:
            begin
                if (hit)
                begin
                    out_next.out_red   = stored.red;
                    out_next.out_green = stored.green;
                    out_next.out_blue  = stored.blue;
                end
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vmlp_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = vmlp_pkg::ST_IDLE;
                end
            end
            vmlp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (samples.data.op == vmlp_pkg::OP_PLOT) ?
                                 vmlp_pkg::ST_MAP_S : vmlp_pkg::ST_READ;
                end
            end
            vmlp_pkg::ST_MAP_S:  state_next = vmlp_pkg::ST_MAP_P;
            vmlp_pkg::ST_MAP_P:  state_next = vmlp_pkg::ST_MAP_Q;
            vmlp_pkg::ST_MAP_Q:  state_next = vmlp_pkg::ST_READ;
            vmlp_pkg::ST_READ:   state_next = vmlp_pkg::ST_UPDATE;
            vmlp_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = vmlp_pkg::ST_IDLE;
                end
            end
            default:             state_next = vmlp_pkg::ST_IDLE;
        endcase
    end

    // Outputs per state
    always_comb
    begin
        samples.ready = 1'b0;
        ram_rd_en     = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = cell_addr;
        ram_wr_data   = '0;
        out_load      = 1'b0;
        clr_cnt_next  = clr_cnt_reg;
        unique case (state_reg)
            vmlp_pkg::ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
            end
            vmlp_pkg::ST_IDLE:
            begin
                samples.ready = 1'b1;
            end
            vmlp_pkg::ST_READ:
            begin
                ram_rd_en = hit;
            end
            vmlp_pkg::ST_UPDATE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (replace)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = lit;
                    end
                    else if ((item_reg.op == vmlp_pkg::OP_READ_CLEAR) && hit)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = '0;
                    end
                end
            end
            default:
            begin
                samples.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vmlp_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            offset_reg    <= vmlp_pkg::LIGHTEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= samples.data;
        end
        if (out_load)
        begin
            out_data_reg <= out_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == vmlp_pkg::ST_UPDATE)
        else $error("result appeared without an update step");

    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en))
        else $error("store read and write in the same cycle");

    a_update_write_op: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_wr_en && state_reg == vmlp_pkg::ST_UPDATE) |->
        (item_reg.op == vmlp_pkg::OP_PLOT || item_reg.op == vmlp_pkg::OP_READ_CLEAR))
        else $error("store written by an item that must not modify it");

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vmlp_pkg::ST_CLEAR) |=> !$past(accept))
        else $error("item accepted during clearing pass");
`endif

endmodule
